FILE: rtl/char_literal_escape_decoder_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the character literal escape decoder
// Concurrent assertion forms used by the checker file.
// ----------------------------------------------------------------------------
`ifndef CHAR_LITERAL_ESCAPE_DECODER_UNIT_MACROS_SVH
`define CHAR_LITERAL_ESCAPE_DECODER_UNIT_MACROS_SVH

// Implication checked outside reset.
`define CLED_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define CLED_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Implication checked at every edge, reset included.
`define CLED_ASSERT_ANY(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/cled_pkg.sv
// ----------------------------------------------------------------------------
// cled_pkg
// Types, character codes and helpers for the character literal escape decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cled_pkg;

    localparam int CHAR_W  = 21;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 4;

    typedef logic [CHAR_W-1:0]  t_char;
    typedef logic [VALUE_W-1:0] t_value;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              byte_mode;
        logic              last;
    } t_in;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               valid_res;
    } t_out;

    typedef enum logic [2:0] {
        PH_NORMAL  = 3'd0,
        PH_ESCAPED = 3'd1,
        PH_XDIGITS = 3'd2,
        PH_UOPEN   = 3'd3,
        PH_UDIGITS = 3'd4
    } t_phase;

    typedef struct packed {
        t_phase             phase;
        logic               have_value;
        logic [VALUE_W-1:0] held_value;
        logic               still_ok;
        logic               stopped;
        logic [VALUE_W-1:0] hex_acc;
        logic [COUNT_W-1:0] hex_cnt;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:      PH_NORMAL,
        have_value: 1'b0,
        held_value: '0,
        still_ok:   1'b1,
        stopped:    1'b0,
        hex_acc:    '0,
        hex_cnt:    '0
    };

    localparam logic [COUNT_W-1:0] CNT_MAX = '1;
    localparam logic [COUNT_W-1:0] X_DIGITS = COUNT_W'(2);

    // Character codes.
    localparam t_char CH_QUOTE  = t_char'(8'h27);
    localparam t_char CH_BSLASH = t_char'(8'h5C);
    localparam t_char CH_LBRACE = t_char'(8'h7B);
    localparam t_char CH_RBRACE = t_char'(8'h7D);
    localparam t_char CH_N      = t_char'(8'h6E);
    localparam t_char CH_ZERO   = t_char'(8'h30);
    localparam t_char CH_NINE   = t_char'(8'h39);
    localparam t_char CH_T      = t_char'(8'h74);
    localparam t_char CH_R      = t_char'(8'h72);
    localparam t_char CH_V      = t_char'(8'h76);
    localparam t_char CH_B      = t_char'(8'h62);
    localparam t_char CH_A      = t_char'(8'h61);
    localparam t_char CH_F      = t_char'(8'h66);
    localparam t_char CH_X      = t_char'(8'h78);
    localparam t_char CH_U      = t_char'(8'h75);
    localparam t_char CH_UP_A   = t_char'(8'h41);
    localparam t_char CH_UP_F   = t_char'(8'h46);

    // Values produced by the simple escapes.
    localparam t_value ESC_NL  = t_value'(10);
    localparam t_value ESC_NUL = t_value'(0);
    localparam t_value ESC_TAB = t_value'(9);
    localparam t_value ESC_CR  = t_value'(13);
    localparam t_value ESC_VT  = t_value'(11);
    localparam t_value ESC_BS  = t_value'(8);
    localparam t_value ESC_BEL = t_value'(7);
    localparam t_value ESC_FF  = t_value'(12);
    localparam t_value ESC_BSL = t_value'(92);

    localparam t_value BYTE_MASK = t_value'(8'hFF);

    // Strict hex digit: bit 4 flags a legal digit, bits 3:0 carry its value.
    function automatic logic [4:0] hex_digit(input t_char c);
        logic [4:0] r;
        r = 5'b0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            r = {1'b1, 4'(c - CH_ZERO)};
        end else if (c >= CH_A && c <= CH_F) begin
            r = {1'b1, 4'(c - CH_A + t_char'(10))};
        end else if (c >= CH_UP_A && c <= CH_UP_F) begin
            r = {1'b1, 4'(c - CH_UP_A + t_char'(10))};
        end
        return r;
    endfunction

endpackage

FILE: rtl/cled_step.sv
// ----------------------------------------------------------------------------
// cled_step
// Next-state and result logic for one character of a literal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cled_step
    import cled_pkg::*;
(
    input  t_state i_state,
    input  t_in    i_item,
    output t_state o_state,
    output t_out   o_result
);

    always_comb begin
        t_state     s;
        t_char      c;
        t_value     c32;
        logic [4:0] hd;
        t_value     acc_sh;
        t_value     v;
        logic       ok;

        s   = i_state;
        c   = i_item.byte_mode ? t_char'(i_item.char_code[7:0]) : i_item.char_code;
        c32 = t_value'(c);
        hd  = hex_digit(c);
        acc_sh = {i_state.hex_acc[VALUE_W-5:0], hd[3:0]};

        if (!i_state.stopped) begin
            if (i_state.have_value && !i_item.last) begin
                s.still_ok = 1'b0;
                s.stopped  = 1'b1;
            end else begin
                unique case (i_state.phase)
                    PH_NORMAL: begin
                        if (c == CH_BSLASH) begin
                            s.phase = PH_ESCAPED;
                        end else if (c != CH_QUOTE) begin
                            s.held_value = c32;
                            s.have_value = 1'b1;
                        end
                    end
                    PH_ESCAPED: begin
                        s.have_value = 1'b1;
                        s.phase      = PH_NORMAL;
                        unique case (c)
                            CH_N:      s.held_value = ESC_NL;
                            CH_ZERO:   s.held_value = ESC_NUL;
                            CH_T:      s.held_value = ESC_TAB;
                            CH_R:      s.held_value = ESC_CR;
                            CH_V:      s.held_value = ESC_VT;
                            CH_B:      s.held_value = ESC_BS;
                            CH_A:      s.held_value = ESC_BEL;
                            CH_F:      s.held_value = ESC_FF;
                            CH_BSLASH: s.held_value = ESC_BSL;
                            CH_X: begin
                                s.have_value = i_state.have_value;
                                s.hex_acc    = '0;
                                s.hex_cnt    = '0;
                                s.phase      = PH_XDIGITS;
                            end
                            CH_U: begin
                                if (i_item.byte_mode) begin
                                    s.held_value = c32;
                                end else begin
                                    s.have_value = i_state.have_value;
                                    s.phase      = PH_UOPEN;
                                end
                            end
                            default:   s.held_value = c32;
                        endcase
                    end
                    PH_XDIGITS: begin
                        if (!hd[4]) begin
                            s.still_ok = 1'b0;
                            s.stopped  = 1'b1;
                        end else begin
                            s.hex_acc = acc_sh;
                            s.hex_cnt = i_state.hex_cnt + 1'b1;
                            if (s.hex_cnt >= X_DIGITS) begin
                                s.held_value = acc_sh & BYTE_MASK;
                                s.have_value = 1'b1;
                                s.phase      = PH_NORMAL;
                            end
                        end
                    end
                    PH_UOPEN: begin
                        if (c == CH_LBRACE) begin
                            s.hex_acc = '0;
                            s.hex_cnt = '0;
                            s.phase   = PH_UDIGITS;
                        end else begin
                            s.still_ok = 1'b0;
                            s.stopped  = 1'b1;
                        end
                    end
                    PH_UDIGITS: begin
                        if (c == CH_RBRACE) begin
                            if (i_state.hex_cnt == '0) begin
                                s.still_ok = 1'b0;
                                s.stopped  = 1'b1;
                            end else begin
                                s.held_value = i_state.hex_acc;
                                s.have_value = 1'b1;
                                s.phase      = PH_NORMAL;
                            end
                        end else if (!hd[4] || i_state.hex_acc[VALUE_W-1:VALUE_W-4] != 4'b0)
                        begin
                            // A further nibble would push set bits out of the top.
                            s.still_ok = 1'b0;
                            s.stopped  = 1'b1;
                        end else begin
                            s.hex_acc = acc_sh;
                            if (i_state.hex_cnt != CNT_MAX) begin
                                s.hex_cnt = i_state.hex_cnt + 1'b1;
                            end
                        end
                    end
                    default: begin
                        s.still_ok = 1'b0;
                        s.stopped  = 1'b1;
                    end
                endcase
            end
        end

        // An unfinished hex escape leaves the literal invalid.
        ok = s.still_ok && s.have_value &&
             (s.phase == PH_NORMAL || s.phase == PH_ESCAPED);
        v  = ok ? s.held_value : '0;
        if (i_item.byte_mode) begin
            v = v & BYTE_MASK;
        end
        o_result.value     = v;
        o_result.valid_res = ok;

        o_state = i_item.last ? STATE_RESET : s;
    end

endmodule

FILE: rtl/char_literal_escape_decoder_unit.sv
// ----------------------------------------------------------------------------
// char_literal_escape_decoder_unit
// Decodes a quoted character literal delivered one character per beat.
// ----------------------------------------------------------------------------
// The block takes one character beat every clock cycle and sustains that rate
// for as long as results are taken. Each beat is captured in an input register
// and decoded from there by a combinational update of the literal state; a beat
// marked last leaves its result in the output register, from which the result
// is offered. The decode loop through the literal state register sets the rate.
// A result waiting in the output register stalls only a further last beat;
// other characters keep flowing.
`timescale 1ns / 1ps

module char_literal_escape_decoder_unit
    import cled_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic   r_in_valid;
    t_in    r_in;
    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    t_out   r_out;
    t_out   n_out;

    logic out_free;
    logic advance;

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && (!r_in.last || out_free);
    assign o_in_ready = !r_in_valid || advance;

    cled_step u_step (
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in.last) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/cled_checker.sv
// ----------------------------------------------------------------------------
// cled_checker
// Port-level checks for the character literal escape decoder, with its bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "char_literal_escape_decoder_unit_macros.svh"

module cled_checker
    import cled_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    // A result beat that is not taken stays offered.
    `CLED_ASSERT_NXT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready, o_out_valid, "result beat dropped before accept")

    // Its payload holds while it waits.
    `CLED_ASSERT_NXT(a_out_stable, i_clk, i_rst_n,
        o_out_valid && !i_out_ready, $stable(o_out_data), "result payload changed while stalled")

    // An invalid literal always reports a zero value.
    `CLED_ASSERT_IMP(a_invalid_zero, i_clk, i_rst_n,
        o_out_valid && !o_out_data.valid_res, o_out_data.value == '0, "invalid result with nonzero value")

    // Reset empties the pipeline: nothing offered and input open.
    `CLED_ASSERT_ANY(a_reset_empty, i_clk,
        $past(i_rst_n) == 1'b0, !o_out_valid && o_in_ready, "pipeline not empty after reset")

endmodule

bind char_literal_escape_decoder_unit cled_checker u_cled_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
